[sv/lscd_pkg.sv]
`timescale 1ns / 1ps

package lscd_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W = 6;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CONN_SEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ONE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_TWO = 2'd2;

   // Check window: the verdict arrives with byte position CHECK_LEN-1, counted from zero at a restart.
   localparam logic [POS_W-1:0] CHECK_LEN = 6'd62;
   localparam logic [POS_W-1:0] CHECK_POS_HEAD = 6'd0;
   localparam logic [POS_W-1:0] CHECK_POS_MID = 6'd30;
   localparam logic [POS_W-1:0] CHECK_POS_TAIL = 6'd60;
   localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'h80;
   localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

   // Seed mixing constants for the table load.
   localparam logic [15:0] SEED_MIX_LOW_HI = 16'h1357;
   localparam logic [15:0] SEED_MIX_LOW_LO = 16'hAAAA;
   localparam logic [15:0] SEED_MIX_HIGH_HI = 16'hABCD;
   localparam logic [15:0] SEED_MIX_HIGH_LO = 16'h4321;

   typedef struct packed {
      logic step;
      logic restart;
   } ks_ctrl_type;

endpackage

[sv/lscd_if.sv]
`timescale 1ns / 1ps

interface lscd_req_if;
   import lscd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] cipher_byte;
   logic              restart;

   modport source (output valid, output cipher_byte, output restart, input ready);
   modport sink (input valid, input cipher_byte, input restart, output ready);
endinterface

interface lscd_rsp_if;
   import lscd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] plain_byte;
   logic              check_done;
   logic              key_valid;

   modport source (output valid, output plain_byte, output check_done, output key_valid,
                   input ready);
   modport sink (input valid, input plain_byte, input check_done, input key_valid,
                 output ready);
endinterface

[sv/login_stream_cipher_decrypt_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                                  Handshake
// req_ch    in         cipher_byte[7:0], restart                valid / ready
// rsp_ch    out        plain_byte[7:0], check_done, key_valid   valid / ready
// csr_*     in         csr_index[1:0], csr_wdata[31:0]          csr_we, no wait
//
// One request is accepted per cycle while the output register is empty or being read; its
// response appears in the output register in the next cycle, so throughput is one byte per clock.
// The table update and the 32-bit key decrement sit in that single register-to-register path.
// A held response does not stall input as long as it is taken in the same cycle.
// Synchronous reset clears the tables and byte position, sets the check flag and empties the
// output register; the configuration registers then read zero.

module login_stream_cipher_decrypt_top
   import lscd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   lscd_req_if.sink             req_ch,
   lscd_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [WORD_W-1:0] conn_seed_ff, key_one_ff, key_two_ff;
   logic [POS_W-1:0]  pos_ff, pos_in, pos_cur;
   logic              check_ok_ff, check_ok_in, check_ok_cur;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] plain_byte_ff, plain_byte_in;
   logic              check_done_ff, check_done_in;
   logic              key_valid_ff, key_valid_in;
   logic              req_accept;
   logic              in_window;
   logic              mismatch;
   logic [BYTE_W-1:0] key_byte;
   ks_ctrl_type       ks_ctrl;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign ks_ctrl.step    = req_accept;
   assign ks_ctrl.restart = req_ch.restart;

   lscd_keystream u_keystream (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ks_ctrl),
      .conn_seed (conn_seed_ff),
      .key_one   (key_one_ff),
      .key_two   (key_two_ff),
      .key_byte  (key_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_seed_ff <= '0;
         key_one_ff   <= '0;
         key_two_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CONN_SEED: conn_seed_ff <= csr_wdata;
            CSR_KEY_ONE:   key_one_ff   <= csr_wdata;
            CSR_KEY_TWO:   key_two_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pos_cur      = req_ch.restart ? '0 : pos_ff;
   assign check_ok_cur = req_ch.restart ? 1'b1 : check_ok_ff;
   assign in_window    = pos_cur < CHECK_LEN;
   assign plain_byte_in = req_ch.cipher_byte ^ key_byte;

   assign mismatch = ((pos_cur == CHECK_POS_HEAD) && (plain_byte_in != HEAD_BYTE)) ||
                     (((pos_cur == CHECK_POS_MID) || (pos_cur == CHECK_POS_TAIL)) &&
                      (plain_byte_in != ZERO_BYTE));

   // The verdict includes the byte that closes the window.
   assign check_ok_in   = req_accept ? (check_ok_cur && !(in_window && mismatch)) : check_ok_ff;
   assign check_done_in = in_window && (pos_cur == CHECK_LEN - 6'd1);
   assign key_valid_in  = check_done_in && check_ok_in;

   always_comb begin
      pos_in = pos_ff;
      if (req_accept) begin
         pos_in = in_window ? pos_cur + 6'd1 : pos_cur;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         check_ok_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         check_ok_ff  <= check_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         plain_byte_ff <= plain_byte_in;
         check_done_ff <= check_done_in;
         key_valid_ff  <= key_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.plain_byte = plain_byte_ff;
   assign rsp_ch.check_done = check_done_ff;
   assign rsp_ch.key_valid  = key_valid_ff;

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= CHECK_LEN)
      else $error("byte position ran past the check window");

   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request left no response");

   a_restart_position: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.restart) |=> (pos_ff == 6'd1))
      else $error("restart did not rewind the byte position");

   a_verdict_only_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && key_valid_ff |-> check_done_ff)
      else $error("key verdict outside the check byte");

endmodule

[sv/lscd_keystream.sv]
`timescale 1ns / 1ps

module lscd_keystream
   import lscd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ks_ctrl_type       ctrl,
   input  logic [WORD_W-1:0] conn_seed,
   input  logic [WORD_W-1:0] key_one,
   input  logic [WORD_W-1:0] key_two,
   output logic [BYTE_W-1:0] key_byte
);

   logic [WORD_W-1:0] table_low_ff, table_low_in;
   logic [WORD_W-1:0] table_high_ff, table_high_in;
   logic [WORD_W-1:0] cur_low, cur_high;
   logic [WORD_W-1:0] load_low, load_high;
   logic [WORD_W-1:0] key_one_dec;
   logic [WORD_W-1:0] mix_high;
   logic [WORD_W-1:0] next_low, next_high;

   assign load_low  = {(~conn_seed[15:0]) ^ SEED_MIX_LOW_HI,
                       conn_seed[15:0] ^ SEED_MIX_LOW_LO};
   assign load_high = {(~conn_seed[31:16]) ^ SEED_MIX_HIGH_HI,
                       conn_seed[31:16] ^ SEED_MIX_HIGH_LO};

   // A restart request decrypts with freshly loaded tables.
   assign cur_low  = ctrl.restart ? load_low : table_low_ff;
   assign cur_high = ctrl.restart ? load_high : table_high_ff;
   assign key_byte = cur_low[BYTE_W-1:0];

   // The low table's bit 0 is shifted into the high table twice.
   assign key_one_dec = key_one - 32'd1;
   assign mix_high    = {cur_low[0], cur_high[WORD_W-1:1]} ^ key_one_dec;
   assign next_high   = {cur_low[0], mix_high[WORD_W-1:1]} ^ key_one;
   assign next_low    = {cur_high[0], cur_low[WORD_W-1:1]} ^ key_two;

   always_comb begin
      table_low_in  = table_low_ff;
      table_high_in = table_high_ff;
      if (ctrl.step) begin
         table_low_in  = next_low;
         table_high_in = next_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_low_ff  <= '0;
         table_high_ff <= '0;
      end else begin
         table_low_ff  <= table_low_in;
         table_high_ff <= table_high_in;
      end
   end

endmodule
